### hw/rtl/floyd_steinberg_rgb_dither_assert.svh
// Assertion macros used by the dither top module.
// Each macro expects clk and rst_n in scope.
`ifndef FLOYD_STEINBERG_RGB_DITHER_ASSERT_SVH
`define FLOYD_STEINBERG_RGB_DITHER_ASSERT_SVH
`ifndef SYNTHESIS
`define FSRD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fsrd assertion failed");
`define FSRD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fsrd assertion failed");
`else
`define FSRD_ASSERT_SAME(lbl, ante, cons)
`define FSRD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/fsrd_pkg.sv
package fsrd_pkg;

  // Line store geometry and error precision
  localparam int MAX_WIDTH  = 1024;
  localparam int ERROR_BITS = 12;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int LW_W   = 11;
  localparam int THR_W  = 8;
  localparam int PIX_W  = 8;
  localparam int CMP_W  = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;
  localparam int ERR_W  = ERROR_BITS;
  localparam int SUM_W  = ERR_W + 2;
  localparam int RND_W  = SUM_W - 4;
  localparam int CORR_W = RND_W + 1;
  // Unit error of one channel: -255..254
  localparam int LERR_W = 9;
  localparam int LANES  = 3;
  localparam int WORD_W = LANES * ERR_W;

  // Configuration register indexes
  typedef enum logic {
    REG_LINE_WIDTH = 1'b0,
    REG_THRESHOLD  = 1'b1
  } fsrd_reg_t;

  // Per-word control handed to every lane
  typedef struct packed {
    logic proc;
    logic sof;
    logic last;
    logic first;
  } fsrd_lane_ctl_t;

  // Clamp a wide sum to the signed error range of the line store
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((64'sd1 <<< (ERR_W - 1)) - 64'sd1);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      sat_err = hi[ERR_W-1:0];
    end else if (v < lo) begin
      sat_err = lo[ERR_W-1:0];
    end else begin
      sat_err = v[ERR_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/fsrd_line_store.sv
module fsrd_line_store import fsrd_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [COL_W-1:0]  rd_addr,
  input  logic              wr_en,
  input  logic [COL_W-1:0]  wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_q_r;
  logic              byp_r;
  logic [WORD_W-1:0] byp_data_r;

  // Write one row entry, read one with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Forward a word written in the same cycle as it is read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

### hw/rtl/fsrd_lane.sv
module fsrd_lane import fsrd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fsrd_lane_ctl_t          ctl,
  input  logic [THR_W-1:0]        thr,
  input  logic [PIX_W-1:0]        pix,
  input  logic signed [ERR_W-1:0] above,
  output logic                    on,
  output logic signed [ERR_W-1:0] wr_left,
  output logic signed [ERR_W-1:0] wr_here
);

  logic signed [LERR_W-1:0] rc_r;
  logic signed [ERR_W-1:0]  bp_r;

  logic signed [LERR_W-1:0] rc_e;
  logic signed [ERR_W-1:0]  bp_e;
  logic signed [ERR_W-1:0]  ab;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [CORR_W-1:0] corr;
  logic [PIX_W-1:0]         corr8;
  logic signed [LERR_W-1:0] err;
  logic signed [SUM_W-1:0]  left_sum;
  logic signed [ERR_W-1:0]  bp_n;

  // Drop carries at the start of a frame, drop the line store in the first row
  assign rc_e = ctl.sof ? '0 : rc_r;
  assign bp_e = ctl.sof ? '0 : bp_r;
  assign ab   = ctl.first ? '0 : above;

  // Corrected value: pixel plus rounded error sum, clamped to 0..255
  always_comb begin
    sum  = SUM_W'(ab) + (SUM_W'(rc_e) <<< 3) - SUM_W'(rc_e);
    rnd  = (sum + SUM_W'(8)) >>> 4;
    corr = CORR_W'(signed'({1'b0, pix})) + CORR_W'(signed'(rnd[RND_W-1:0]));
    if (corr < 0) begin
      corr8 = '0;
    end else if (corr > CORR_W'(255)) begin
      corr8 = '1;
    end else begin
      corr8 = corr[PIX_W-1:0];
    end
  end

  // Quantise and take the unit error
  assign on  = (corr8 >= thr);
  assign err = on ? (signed'({1'b0, corr8}) - LERR_W'(255)) : signed'({1'b0, corr8});

  // Next-row sums: finish the left column, open this one
  assign left_sum = SUM_W'(bp_e) + SUM_W'(err) + (SUM_W'(err) <<< 1);
  assign wr_left  = sat_err(left_sum);
  assign bp_n     = (ERR_W'(err) <<< 2) + ERR_W'(err) + ERR_W'(rc_e);
  assign wr_here  = bp_n;

  // Advance the row carries, clear them at the end of a row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= '0;
      bp_r <= '0;
    end else if (ctl.proc) begin
      if (ctl.last) begin
        rc_r <= '0;
        bp_r <= '0;
      end else begin
        rc_r <= err;
        bp_r <= bp_n;
      end
    end
  end

endmodule

### hw/rtl/floyd_steinberg_rgb_dither.sv
// Stages: line-store read, then diffusion, which closes the right-neighbour error loop.
// Throughput: one pixel per cycle while the output register is not stalled by out_ready.
// Line store: 1024 x 36-bit single-write memory with same-cycle read forwarding.
// Reset (rst_n low, synchronous): empties the pipeline, clears row carries and column,
// sets first row, line_width 640, threshold 128; the line store is not cleared.
module floyd_steinberg_rgb_dither import fsrd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] in_red,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_blue,
  input  logic             in_start_of_frame,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_red_on,
  output logic             out_green_on,
  output logic             out_blue_on,
  output logic             out_end_of_row,
  input  logic             cfg_we,
  input  fsrd_reg_t        cfg_index,
  input  logic [LW_W-1:0]  cfg_data
);

  `include "floyd_steinberg_rgb_dither_assert.svh"

  logic [LW_W-1:0]  line_width_r;
  logic [THR_W-1:0] threshold_r;
  logic [COL_W-1:0] col_r;
  logic             first_row_r;

  logic             p_valid_r;
  logic [PIX_W-1:0] p_pix_r [LANES];
  logic [COL_W-1:0] p_x_r;
  logic             p_last_r;
  logic             p_first_r;
  logic             p_sof_r;

  logic              dfr_valid_r;
  logic [COL_W-1:0]  dfr_addr_r;
  logic [WORD_W-1:0] dfr_data_r;

  logic             out_valid_r;
  logic             red_on_r;
  logic             green_on_r;
  logic             blue_on_r;
  logic             end_of_row_r;

  logic [CMP_W-1:0] width_eff;
  logic [COL_W-1:0] acc_x;
  logic             acc_last;
  logic             acc_first;
  logic             acc;
  logic             proc;
  logic             has_left;

  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;
  logic [WORD_W-1:0] left_word;
  logic [WORD_W-1:0] here_word;
  logic [LANES-1:0]  lane_on;
  fsrd_lane_ctl_t    lane_ctl;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LW_W'(640);
      threshold_r  <= THR_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH: line_width_r <= cfg_data;
        REG_THRESHOLD:  threshold_r  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the diffusion stage drains into the output register
  assign proc     = p_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !p_valid_r || proc;
  assign acc      = in_valid && in_ready;

  // Row position of the arriving word
  always_comb begin
    if (line_width_r == '0) begin
      width_eff = CMP_W'(1);
    end else if (CMP_W'(line_width_r) > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = CMP_W'(line_width_r);
    end
    acc_x     = in_start_of_frame ? '0 : col_r;
    acc_last  = (CMP_W'(acc_x) + CMP_W'(1)) >= width_eff;
    acc_first = in_start_of_frame || first_row_r;
  end

  // Advance column and first-row flag on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      first_row_r <= 1'b1;
    end else if (acc) begin
      col_r       <= acc_last ? '0 : acc_x + COL_W'(1);
      first_row_r <= acc_last ? 1'b0 : acc_first;
    end
  end

  // Hold the word while its line-store entry is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (acc) begin
      p_valid_r <= 1'b1;
    end else if (proc) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p_pix_r[0] <= in_red;
      p_pix_r[1] <= in_green;
      p_pix_r[2] <= in_blue;
      p_x_r      <= acc_x;
      p_last_r   <= acc_last;
      p_first_r  <= acc_first;
      p_sof_r    <= in_start_of_frame;
    end
  end

  fsrd_line_store u_line_store (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (acc_x),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // Channel lanes
  assign lane_ctl.proc  = proc;
  assign lane_ctl.sof   = p_sof_r;
  assign lane_ctl.last  = p_last_r;
  assign lane_ctl.first = p_first_r;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    fsrd_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (lane_ctl),
      .thr     (threshold_r),
      .pix     (p_pix_r[g]),
      .above   (rd_data[g*ERR_W +: ERR_W]),
      .on      (lane_on[g]),
      .wr_left (left_word[g*ERR_W +: ERR_W]),
      .wr_here (here_word[g*ERR_W +: ERR_W])
    );
  end

  // Merge lanes into the line-store write; the end-of-row entry is written in the next cycle
  // when the left entry takes the port
  assign has_left = (p_x_r != '0);

  always_comb begin
    wr_en   = dfr_valid_r || (proc && (has_left || p_last_r));
    wr_addr = dfr_addr_r;
    wr_data = dfr_data_r;
    priority if (dfr_valid_r) begin
      wr_addr = dfr_addr_r;
      wr_data = dfr_data_r;
    end else if (has_left) begin
      wr_addr = p_x_r - COL_W'(1);
      wr_data = left_word;
    end else begin
      wr_addr = p_x_r;
      wr_data = here_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfr_valid_r <= 1'b0;
    end else begin
      dfr_valid_r <= proc && p_last_r && has_left;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      dfr_addr_r <= p_x_r;
      dfr_data_r <= here_word;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      red_on_r     <= lane_on[0];
      green_on_r   <= lane_on[1];
      blue_on_r    <= lane_on[2];
      end_of_row_r <= p_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_on     = red_on_r;
  assign out_green_on   = green_on_r;
  assign out_blue_on    = blue_on_r;
  assign out_end_of_row = end_of_row_r;

  // A pending end-of-row entry never meets a diffusion-stage write
  `FSRD_ASSERT_SAME(a_dfr_no_clash, dfr_valid_r, !(proc && (has_left || p_last_r)))
  // A pending entry only follows an end-of-row word past column zero
  `FSRD_ASSERT_SAME(a_dfr_origin, dfr_valid_r, $past(proc && p_last_r && has_left))
  // The column restarts after a word that ends its row
  `FSRD_ASSERT_NEXT(a_col_wrap, acc && acc_last, col_r == '0 && !first_row_r)
  // Every diffused word lands in the output register
  `FSRD_ASSERT_NEXT(a_proc_out, proc, out_valid_r && (end_of_row_r == $past(p_last_r)))

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsrd_pkg::*;

  // One input word and one output word of the dither
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             sof;
  } pixel_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
    logic end_of_row;
  } dot_t;

  // Cycles with no word moving on either side before the run is abandoned
  localparam int QUIET_LIMIT = 2000;
  // Long receiver hold-off, and the output count at which it starts
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 320;

  // Error-diffusion predictor and the queue of dots it still owes
  class dither_scoreboard;
    logic signed [ERR_W-1:0] row_err [MAX_WIDTH][LANES];
    bit                      row_written [MAX_WIDTH];
    int                      right_err [LANES];
    int                      below_sum [LANES];
    int                      col;
    bit                      top_row;
    logic [LW_W-1:0]         width_reg;
    logic [THR_W-1:0]        thr_reg;
    dot_t                    dots_due [$];
    int                      n_fail;
    int                      n_checked;
    int                      n_row_ends;
    int                      n_frames;
    int                      n_clamps;

    function new();
      int c;
      foreach (row_written[i]) row_written[i] = 1'b0;
      for (c = 0; c < LANES; c++) begin
        right_err[c] = 0;
        below_sum[c] = 0;
      end
      col        = 0;
      top_row    = 1'b1;
      width_reg  = 11'd640;
      thr_reg    = 8'd128;
      n_fail     = 0;
      n_checked  = 0;
      n_row_ends = 0;
      n_frames   = 0;
      n_clamps   = 0;
    endfunction

    // Saturate a next-row sum to the signed range of the line store
    function logic signed [ERR_W-1:0] clamp_err(input int v);
      int hi;
      int lo;
      hi = (1 << (ERR_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
        n_clamps++;
        return ERR_W'(hi);
      end
      if (v < lo) begin
        n_clamps++;
        return ERR_W'(lo);
      end
      return ERR_W'(v);
    endfunction

    // True when the next word, without a frame start, would read a line entry never written
    function bit reads_unwritten();
      return !top_row && !row_written[col];
    endfunction

    function int pending();
      return dots_due.size();
    endfunction

    // Advance the predictor by one accepted pixel and queue the dot it yields
    function void note_input(input pixel_t p);
      logic [PIX_W-1:0] px [LANES];
      logic [LANES-1:0] lit;
      int               w;
      int               x;
      int               c;
      int               above;
      int               corr;
      int               err;
      bit               last;
      dot_t             d;
      px[0] = p.red;
      px[1] = p.green;
      px[2] = p.blue;
      w = int'(width_reg);
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      // Frame start: drop the row carries before this pixel
      if (p.sof) begin
        for (c = 0; c < LANES; c++) begin
          right_err[c] = 0;
          below_sum[c] = 0;
        end
        col     = 0;
        top_row = 1'b1;
        n_frames++;
      end
      x    = (col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col;
      last = (x + 1 >= w);
      for (c = 0; c < LANES; c++) begin
        above = top_row ? 0 : int'(row_err[x][c]);
        corr  = int'(px[c]) + ((above + 7 * right_err[c] + 8) >>> 4);
        if (corr < 0) corr = 0;
        if (corr > 255) corr = 255;
        lit[c] = (corr >= int'(thr_reg));
        err    = lit[c] ? corr - 255 : corr;
        // Finish the below-left sum of the previous column
        if (x > 0) row_err[x-1][c] = clamp_err(below_sum[c] + 3 * err);
        below_sum[c] = 5 * err + right_err[c];
        if (last) begin
          row_err[x][c] = clamp_err(below_sum[c]);
          below_sum[c]  = 0;
          right_err[c]  = 0;
        end else begin
          right_err[c] = err;
        end
      end
      if (x > 0) row_written[x-1] = 1'b1;
      if (last) row_written[x] = 1'b1;
      if (last) begin
        col     = 0;
        top_row = 1'b0;
      end else begin
        col = x + 1;
      end
      d.red_on     = lit[0];
      d.green_on   = lit[1];
      d.blue_on    = lit[2];
      d.end_of_row = last;
      dots_due.push_back(d);
    endfunction

    function void compare_field(input string field, input logic want, input logic got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %b, got %b", $time, field, want, got);
        n_fail++;
      end
    endfunction

    // Compare one output word with the oldest dot owed
    function void check_output(input dot_t got);
      dot_t want;
      if (dots_due.size() == 0) begin
        $display("%0t: output word with none expected: expected nothing, got %b", $time, got);
        n_fail++;
        return;
      end
      want = dots_due.pop_front();
      n_checked++;
      if (want.end_of_row) n_row_ends++;
      compare_field("red_on", want.red_on, got.red_on);
      compare_field("green_on", want.green_on, got.green_on);
      compare_field("blue_on", want.blue_on, got.blue_on);
      compare_field("end_of_row", want.end_of_row, got.end_of_row);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [PIX_W-1:0] in_red;
  logic [PIX_W-1:0] in_green;
  logic [PIX_W-1:0] in_blue;
  logic             in_start_of_frame;
  logic             out_valid;
  logic             out_ready;
  logic             out_red_on;
  logic             out_green_on;
  logic             out_blue_on;
  logic             out_end_of_row;
  logic             cfg_we;
  fsrd_reg_t        cfg_index;
  logic [LW_W-1:0]  cfg_data;

  dither_scoreboard sb = new();
  bit               steady = 1'b0;
  int               grey = 128;
  int               n_settings = 1;

  always #2 clk = ~clk;

  floyd_steinberg_rgb_dither dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_start_of_frame (in_start_of_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_red_on        (out_red_on),
    .out_green_on      (out_green_on),
    .out_blue_on       (out_blue_on),
    .out_end_of_row    (out_end_of_row),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Idle length: mostly none or short, now and then long; none in steady phases
  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Channel value: extremes, noise round the phase's grey level, or anything
  function automatic logic [PIX_W-1:0] rand_chan();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 255;
      2, 3, 4, 5: v = grey + int'($urandom_range(0, 16)) - 8;
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  function automatic pixel_t make_pixel(input logic [PIX_W-1:0] r, g, b, input logic s);
    pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.sof   = s;
    return p;
  endfunction

  // Offer one pixel and hold it until taken; entered and left at a falling edge
  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_red            <= p.red;
    in_green          <= p.green;
    in_blue           <= p.blue;
    in_start_of_frame <= p.sof;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_input(p);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed dot is out
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers on back-to-back edges; only while idle
  task automatic configure(input logic [LW_W-1:0] w, input logic [THR_W-1:0] t);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= LW_W'(t);
    @(negedge clk);
    cfg_we       <= 1'b0;
    sb.width_reg = w;
    sb.thr_reg   = t;
    n_settings++;
  endtask

  // One random phase: frames of random content, rare mid-frame restarts
  task automatic run_phase(input logic [LW_W-1:0] w, input logic [THR_W-1:0] t,
                           input int n, input bit open_frame, input bit calm);
    pixel_t p;
    int     k;
    configure(w, t);
    steady = calm;
    grey   = $urandom_range(0, 255);
    for (k = 0; k < n; k++) begin
      p.red   = rand_chan();
      p.green = rand_chan();
      p.blue  = rand_chan();
      // Force a frame start rather than read a line entry never written
      p.sof   = (k == 0 && open_frame) || ($urandom_range(0, 49) == 0) || sb.reads_unwritten();
      send_pixel(p);
    end
    drain();
    steady = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going
  initial begin : result_sink
    int stall;
    int hold;
    bit held;
    stall     = 0;
    hold      = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && sb.n_checked >= HOLD_AFTER) begin
        hold = HOLD_CYCLES;
        held = 1'b1;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = idle_gap();
      end
    end
  end

  // Check every output word taken
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      sb.check_output({out_red_on, out_green_on, out_blue_on, out_end_of_row});
  end

  // Abandon the run when no word moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no word moved for %0d cycles, %0d dots still owed",
             $time, QUIET_LIMIT, sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    in_valid          = 1'b0;
    in_red            = '0;
    in_green          = '0;
    in_blue           = '0;
    in_start_of_frame = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_LINE_WIDTH;
    cfg_data          = '0;
    rst_n             = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: full-scale and alternating bit patterns in a wide row
    send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b1));
    send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(make_pixel(8'hAA, 8'h55, 8'h80, 1'b0));
    send_pixel(make_pixel(8'h7F, 8'h80, 8'h01, 1'b0));
    drain();

    // Narrow rows: row ends, line store reads, frame restart in mid row
    configure(11'd4, 8'd128);
    send_pixel(make_pixel(8'd255, 8'd0, 8'd128, 1'b1));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd127, 1'b0));
    send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 1'b0));
    send_pixel(make_pixel(8'd127, 8'd129, 8'd1, 1'b0));
    send_pixel(make_pixel(8'd254, 8'd1, 8'd200, 1'b0));
    send_pixel(make_pixel(8'd90, 8'd200, 8'd30, 1'b1));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd100, 8'd100, 8'd100, 1'b0));
    send_pixel(make_pixel(8'd128, 8'd64, 8'd192, 1'b0));
    drain();

    // Threshold zero on black: every channel lights and the line store saturates
    configure(11'd4, 8'd0);
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b1));
    repeat (7) send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
    drain();

    // Random phases over widths and thresholds, extremes among them
    run_phase(11'd2, 8'd200, 60, 1'b1, 1'b0);
    run_phase(11'd1, 8'd50, 30, 1'b1, 1'b1);
    run_phase(11'd0, 8'd128, 20, 1'b1, 1'b0);
    run_phase(11'd17, 8'd1, 90, 1'b1, 1'b0);
    run_phase(11'd7, 8'd255, 80, 1'b1, 1'b1);
    run_phase(11'd1024, 8'd128, 160, 1'b1, 1'b0);
    // Narrower width with no frame start: a pixel at or past the new width ends the row
    run_phase(11'd5, 8'd90, 70, 1'b0, 1'b0);
    run_phase(11'd2047, THR_W'($urandom_range(1, 255)), 40, 1'b1, 1'b0);
    run_phase(11'd3, 8'd0, 50, 1'b1, 1'b0);
    run_phase(LW_W'($urandom_range(2, 40)), THR_W'($urandom_range(1, 255)), 100, 1'b1,
              1'b0);

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d pixels in %0d frame starts and %0d row ends over %0d settings,",
             sb.n_checked, sb.n_frames, sb.n_row_ends, n_settings);
    $display("widths 0 to 2047, thresholds 0 to 255, %0d line-store clamps.", sb.n_clamps);
    if (sb.n_fail == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
